@@ rtl/core/sobel_edge_magnitude_top_assert.svh @@
// Assertion macros for the Sobel edge magnitude block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SEM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sobel edge magnitude assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sobel edge magnitude assertion failed");

`endif

@@ rtl/core/sem_pkg.sv @@
`timescale 1ns / 1ps

package sem_pkg;

  localparam int unsigned MAX_COLS = 2048;
  localparam int unsigned MAX_ROWS = 4096;
  localparam int unsigned COL_W    = $clog2(MAX_COLS);
  localparam int unsigned ROW_W    = $clog2(MAX_ROWS);
  localparam int unsigned PIX_W    = 8;

  // Configuration register widths, reset values and lower limit.
  localparam int unsigned COLS_REG_W = 12;
  localparam int unsigned ROWS_REG_W = 13;
  localparam int unsigned COLS_RESET = 640;
  localparam int unsigned ROWS_RESET = 480;
  localparam int unsigned MIN_SIZE   = 3;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_IDX_COLS = 1'b0;
  localparam logic REG_IDX_ROWS = 1'b1;

  // Gradient magnitudes are at most 4 * 255, their squares sum to 21 bits.
  localparam int unsigned GRAD_W = 10;
  localparam int unsigned SQ_W   = 2 * GRAD_W;
  localparam int unsigned ACC_W  = SQ_W + 1;
  localparam int unsigned BIT_W  = $clog2(PIX_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT,
    ST_DELIVER
  } state_e;

endpackage

@@ rtl/core/sem_ram.sv @@
`timescale 1ns / 1ps

module sem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sobel_edge_magnitude_top.sv @@
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_stall_o      pixel_i
// out       output     out_valid_o / out_stall_i    edge_res_o, center_row_o,
//                                                   center_col_o, frame_end_o
// cfg       input      APB access, pready always 1  image_cols, image_rows
//
// One pixel is worked on at a time. A pixel with no result passes idle and
// read, a border result then delivers, and an interior result squares both
// gradients on a shared multiplier and takes an eight-bit bit-serial square
// root before delivery. The finished result sits in an output register, so
// the next pixel is taken while it waits. Reset clears the counters, the
// window and the output valid flag; the line store needs no clearing.
`timescale 1ns / 1ps

`include "sobel_edge_magnitude_top_assert.svh"

module sobel_edge_magnitude_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sem_pkg::PIX_W-1:0]       pixel_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sem_pkg::PIX_W-1:0]       edge_res_o,
  output logic [sem_pkg::ROW_W-1:0]       center_row_o,
  output logic [sem_pkg::COL_W-1:0]       center_col_o,
  output logic                            frame_end_o,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sem_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sem_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sem_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned PW = sem_pkg::PIX_W;
  localparam int unsigned CW = sem_pkg::COL_W;
  localparam int unsigned RW = sem_pkg::ROW_W;
  localparam int unsigned GW = sem_pkg::GRAD_W;
  localparam int unsigned CRW = sem_pkg::COLS_REG_W;
  localparam int unsigned RRW = sem_pkg::ROWS_REG_W;

  // Configuration registers.
  logic [CRW-1:0] image_cols_q;
  logic [RRW-1:0] image_rows_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_cols_q <= CRW'(sem_pkg::COLS_RESET);
      image_rows_q <= RRW'(sem_pkg::ROWS_RESET);
    end else if (cfg_wr) begin
      case (paddr[2])
        sem_pkg::REG_IDX_COLS: image_cols_q <= pwdata[CRW-1:0];
        sem_pkg::REG_IDX_ROWS: image_rows_q <= pwdata[RRW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      sem_pkg::REG_IDX_COLS: prdata = sem_pkg::APB_DATA_W'(image_cols_q);
      sem_pkg::REG_IDX_ROWS: prdata = sem_pkg::APB_DATA_W'(image_rows_q);
      default:               prdata = '0;
    endcase
  end

  // Out-of-range sizes are clamped to the supported range.
  logic [CRW-1:0] cols_eff;
  logic [RRW-1:0] rows_eff;

  always_comb begin
    if (image_cols_q < CRW'(sem_pkg::MIN_SIZE)) begin
      cols_eff = CRW'(sem_pkg::MIN_SIZE);
    end else if (image_cols_q > CRW'(sem_pkg::MAX_COLS)) begin
      cols_eff = CRW'(sem_pkg::MAX_COLS);
    end else begin
      cols_eff = image_cols_q;
    end
    if (image_rows_q < RRW'(sem_pkg::MIN_SIZE)) begin
      rows_eff = RRW'(sem_pkg::MIN_SIZE);
    end else if (image_rows_q > RRW'(sem_pkg::MAX_ROWS)) begin
      rows_eff = RRW'(sem_pkg::MAX_ROWS);
    end else begin
      rows_eff = image_rows_q;
    end
  end

  // Sequencer.
  sem_pkg::state_e state_q, state_d;

  logic                    accept;
  logic                    out_free;
  logic                    ram_re;
  logic                    ram_we;
  logic                    out_load;
  logic [sem_pkg::BIT_W-1:0] bit_q;
  logic                    emit_q;
  logic                    calc_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sem_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sem_pkg::ST_READ;
        end
      end
      sem_pkg::ST_READ: begin
        if (!emit_q) begin
          state_d = sem_pkg::ST_IDLE;
        end else if (calc_q) begin
          state_d = sem_pkg::ST_SQ_X;
        end else begin
          state_d = sem_pkg::ST_DELIVER;
        end
      end
      sem_pkg::ST_SQ_X: state_d = sem_pkg::ST_SQ_Y;
      sem_pkg::ST_SQ_Y: state_d = sem_pkg::ST_ROOT;
      sem_pkg::ST_ROOT: begin
        if (bit_q == '0) begin
          state_d = sem_pkg::ST_DELIVER;
        end
      end
      sem_pkg::ST_DELIVER: begin
        if (out_free) begin
          state_d = sem_pkg::ST_IDLE;
        end
      end
      default: state_d = sem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      sem_pkg::ST_IDLE:    in_stall_o = 1'b0;
      sem_pkg::ST_READ:    ram_we = 1'b1;
      sem_pkg::ST_DELIVER: out_load = out_free;
      default: ;
    endcase
  end

  assign ram_re = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Position counters; they advance when the pixel is taken.
  logic [CW-1:0] col_count_q;
  logic [RW-1:0] row_count_q;
  logic [CW:0]   next_col;
  logic [RW:0]   next_row;
  logic          row_wrap;
  logic          frame_wrap;

  assign next_col   = {1'b0, col_count_q} + 1'b1;
  assign next_row   = {1'b0, row_count_q} + 1'b1;
  assign row_wrap   = next_col >= (CW + 1)'(cols_eff);
  assign frame_wrap = next_row >= (RW + 1)'(rows_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (accept) begin
      if (row_wrap) begin
        col_count_q <= '0;
        row_count_q <= frame_wrap ? '0 : next_row[RW-1:0];
      end else begin
        col_count_q <= next_col[CW-1:0];
      end
    end
  end

  // Per-item registers.
  logic [PW-1:0] pix_q;
  logic [CW-1:0] idx_q;
  logic [RW-1:0] crow_q;
  logic [CW-1:0] ccol_q;
  logic          fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
      calc_q <= 1'b0;
    end else if (accept) begin
      emit_q <= (row_count_q != '0) && (col_count_q != '0);
      calc_q <= (row_count_q[RW-1:1] != '0) && (col_count_q[CW-1:1] != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= pixel_i;
      idx_q  <= col_count_q;
      crow_q <= row_count_q - 1'b1;
      ccol_q <= col_count_q - 1'b1;
      fend_q <= row_wrap && frame_wrap;
    end
  end

  // Both line stores share one memory word: {two rows up, one row up}.
  logic [2*PW-1:0] ram_rdata;
  logic [PW-1:0]   top;
  logic [PW-1:0]   mid;

  sem_ram #(
    .WIDTH (2 * PW),
    .DEPTH (sem_pkg::MAX_COLS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i ({mid, pix_q}),
    .re_i    (ram_re),
    .raddr_i (col_count_q),
    .rdata_o (ram_rdata)
  );

  assign top = ram_rdata[2*PW-1:PW];
  assign mid = ram_rdata[PW-1:0];

  // Window of the two previous columns, top to bottom: 0..2 older, 3..5 newer.
  logic [PW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (ram_we) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= pix_q;
    end
  end

  // Gradients as differences of two weighted sums; only magnitudes matter.
  logic [GW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [GW-1:0] ax, ay;

  assign gx_pos = GW'(top) + GW'({mid, 1'b0}) + GW'(pix_q);
  assign gx_neg = GW'(win_q[0]) + GW'({win_q[1], 1'b0}) + GW'(win_q[2]);
  assign gy_pos = GW'(win_q[2]) + GW'({win_q[5], 1'b0}) + GW'(pix_q);
  assign gy_neg = GW'(win_q[0]) + GW'({win_q[3], 1'b0}) + GW'(top);
  assign ax = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
  assign ay = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;

  logic [GW-1:0]              ax_q, ay_q;
  logic [GW-1:0]              sq_op;
  logic [sem_pkg::SQ_W-1:0]   sq;
  logic [sem_pkg::ACC_W-1:0]  acc_q;
  logic [PW-1:0]              res_q;
  logic [PW-1:0]              trial;
  logic [2*PW-1:0]            trial_sq;

  assign sq_op    = (state_q == sem_pkg::ST_SQ_X) ? ax_q : ay_q;
  assign sq       = sq_op * sq_op;
  assign trial    = res_q | (PW'(1) << bit_q);
  assign trial_sq = trial * trial;

  // The root search covers eight bits, so sums of 255 squared or more
  // settle at 255 without a separate saturation check.
  always_ff @(posedge clk_i) begin
    case (state_q)
      sem_pkg::ST_READ: begin
        ax_q  <= ax;
        ay_q  <= ay;
        res_q <= '0;
        bit_q <= sem_pkg::BIT_W'(PW - 1);
      end
      sem_pkg::ST_SQ_X: acc_q <= sem_pkg::ACC_W'(sq);
      sem_pkg::ST_SQ_Y: acc_q <= acc_q + sem_pkg::ACC_W'(sq);
      sem_pkg::ST_ROOT: begin
        if (sem_pkg::ACC_W'(trial_sq) <= acc_q) begin
          res_q <= trial;
        end
        bit_q <= bit_q - 1'b1;
      end
      default: ;
    endcase
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      edge_res_o   <= res_q;
      center_row_o <= crow_q;
      center_col_o <= ccol_q;
      frame_end_o  <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The line store is written back in the cycle right after a pixel is taken.
  `SEM_ASSERT_NEXT(a_wb_after_accept, accept, ram_we)
  // A new result only appears after the delivery step.
  `SEM_ASSERT_SAME(a_load_from_deliver, $rose(out_valid_q), $past(state_q == sem_pkg::ST_DELIVER))
  // Centres in the first row or column always carry a zero edge value.
  `SEM_ASSERT_SAME(a_border_zero, out_valid_o && (center_row_o == '0 || center_col_o == '0), edge_res_o == '0)

endmodule

@@ verif/sobel_edge_magnitude_checker.sv @@
`timescale 1ns / 1ps

module sobel_edge_magnitude_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [sem_pkg::PIX_W-1:0]      pixel_i,

  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [sem_pkg::PIX_W-1:0]      edge_res_i,
  input  logic [sem_pkg::ROW_W-1:0]      center_row_i,
  input  logic [sem_pkg::COL_W-1:0]      center_col_i,
  input  logic                           frame_end_i,

  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [sem_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [sem_pkg::APB_DATA_W-1:0] pwdata_i,
  input  logic [sem_pkg::APB_DATA_W-1:0] prdata_i,
  input  logic                           pready_i,

  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);

  typedef struct packed {
    logic [sem_pkg::PIX_W-1:0] mag;
    logic [sem_pkg::ROW_W-1:0] row;
    logic [sem_pkg::COL_W-1:0] col;
    logic                      last;
  } edge_item_t;

  // Shadow of the block: size registers, two line stores, the two earlier
  // window columns and the raster position of the next pixel.
  logic [sem_pkg::COLS_REG_W-1:0] cols_reg;
  logic [sem_pkg::ROWS_REG_W-1:0] rows_reg;
  logic [sem_pkg::PIX_W-1:0]      line_prev  [sem_pkg::MAX_COLS];
  logic [sem_pkg::PIX_W-1:0]      line_prev2 [sem_pkg::MAX_COLS];
  logic [sem_pkg::PIX_W-1:0]      win [6];
  logic [sem_pkg::ROW_W-1:0]      pos_row;
  logic [sem_pkg::COL_W-1:0]      pos_col;

  edge_item_t                     expected_edges [$];
  edge_item_t                     want;
  logic [sem_pkg::APB_DATA_W-1:0] reg_value;
  int                             fail_count;
  int                             checked;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_edges.size();
  assign checked_o    = checked;

  task automatic predict_edge(input logic [sem_pkg::PIX_W-1:0] pix);
    int unsigned cols_eff;
    int unsigned rows_eff;
    int unsigned c;
    int unsigned r;
    int unsigned nc;
    int unsigned nr;
    int unsigned sum_sq;
    int unsigned root;
    int unsigned trial;
    int unsigned b;
    int          gx;
    int          gy;
    int          p;
    int          top;
    int          mid;
    edge_item_t  item;
    cols_eff = (cols_reg < sem_pkg::MIN_SIZE) ? sem_pkg::MIN_SIZE :
               (cols_reg > sem_pkg::MAX_COLS) ? sem_pkg::MAX_COLS : cols_reg;
    rows_eff = (rows_reg < sem_pkg::MIN_SIZE) ? sem_pkg::MIN_SIZE :
               (rows_reg > sem_pkg::MAX_ROWS) ? sem_pkg::MAX_ROWS : rows_reg;
    c   = pos_col;
    r   = pos_row;
    p   = pix;
    top = line_prev2[c];
    mid = line_prev[c];
    if (r >= 1 && c >= 1) begin
      root = 0;
      if (r >= 2 && c >= 2) begin
        gx = (top + 2 * mid + p) - (win[0] + 2 * win[1] + win[2]);
        gy = (win[2] + 2 * win[5] + p) - (win[0] + 2 * win[3] + top);
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        sum_sq = gx * gx + gy * gy;
        if (sum_sq >= 65025) begin
          root = 255;
        end else begin
          for (b = 128; b != 0; b = b >> 1) begin
            trial = root | b;
            if (trial * trial <= sum_sq) root = trial;
          end
        end
      end
      item.mag  = root[sem_pkg::PIX_W-1:0];
      item.row  = sem_pkg::ROW_W'(r - 1);
      item.col  = sem_pkg::COL_W'(c - 1);
      item.last = (r + 1 >= rows_eff) && (c + 1 >= cols_eff);
      expected_edges.push_back(item);
    end
    line_prev2[c] = mid[sem_pkg::PIX_W-1:0];
    line_prev[c]  = pix;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top[sem_pkg::PIX_W-1:0];
    win[4] = mid[sem_pkg::PIX_W-1:0];
    win[5] = pix;
    nc = c + 1;
    nr = r;
    if (nc >= cols_eff) begin
      nc = 0;
      nr = r + 1;
      if (nr >= rows_eff) nr = 0;
    end
    pos_col = sem_pkg::COL_W'(nc);
    pos_row = sem_pkg::ROW_W'(nr);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_reg = sem_pkg::COLS_REG_W'(sem_pkg::COLS_RESET);
      rows_reg = sem_pkg::ROWS_REG_W'(sem_pkg::ROWS_RESET);
      for (int i = 0; i < sem_pkg::MAX_COLS; i++) begin
        line_prev[i]  = '0;
        line_prev2[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      pos_row = '0;
      pos_col = '0;
      expected_edges.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == sem_pkg::REG_IDX_COLS) cols_reg = pwdata_i[sem_pkg::COLS_REG_W-1:0];
          else rows_reg = pwdata_i[sem_pkg::ROWS_REG_W-1:0];
        end else begin
          reg_value = (paddr_i[2] == sem_pkg::REG_IDX_COLS) ?
                      sem_pkg::APB_DATA_W'(cols_reg) : sem_pkg::APB_DATA_W'(rows_reg);
          if (prdata_i !== reg_value) begin
            $error("prdata mismatch: expected %0d, actual %0d", reg_value, prdata_i);
            fail_count++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) predict_edge(pixel_i);

      if (out_valid_i && !out_stall_i) begin
        if (expected_edges.size() == 0) begin
          $error("edge result at row %0d col %0d arrived with none outstanding",
                 center_row_i, center_col_i);
          fail_count++;
        end else begin
          want = expected_edges.pop_front();
          checked++;
          if (edge_res_i !== want.mag) begin
            $error("edge_res mismatch: expected %0d, actual %0d", want.mag, edge_res_i);
            fail_count++;
          end
          if (center_row_i !== want.row) begin
            $error("center_row mismatch: expected %0d, actual %0d", want.row, center_row_i);
            fail_count++;
          end
          if (center_col_i !== want.col) begin
            $error("center_col mismatch: expected %0d, actual %0d", want.col, center_col_i);
            fail_count++;
          end
          if (frame_end_i !== want.last) begin
            $error("frame_end mismatch: expected %0d, actual %0d", want.last, frame_end_i);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ verif/sobel_edge_magnitude_top_tb.sv @@
`timescale 1ns / 1ps

module sobel_edge_magnitude_top_tb;

  localparam int RANDOM_ITEMS   = 560;
  // Covers the longest per-pixel work in the block, an interior result; leave some margin.
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [sem_pkg::APB_ADDR_W-1:0] ADDR_COLS = {sem_pkg::REG_IDX_COLS, 2'b00};
  localparam logic [sem_pkg::APB_ADDR_W-1:0] ADDR_ROWS = {sem_pkg::REG_IDX_ROWS, 2'b00};

  typedef enum int {PAT_NOISE, PAT_BINARY, PAT_RAMP, PAT_FLAT} pattern_e;

  logic                           clk_i;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic [sem_pkg::PIX_W-1:0]      pixel     = '0;
  logic                           out_stall = 1'b0;
  logic                           psel      = 1'b0;
  logic                           penable   = 1'b0;
  logic                           pwrite    = 1'b0;
  logic [sem_pkg::APB_ADDR_W-1:0] paddr     = '0;
  logic [sem_pkg::APB_DATA_W-1:0] pwdata    = '0;

  logic                           in_stall;
  logic                           out_valid;
  logic [sem_pkg::PIX_W-1:0]      edge_res;
  logic [sem_pkg::ROW_W-1:0]      center_row;
  logic [sem_pkg::COL_W-1:0]      center_col;
  logic                           frame_end;
  logic [sem_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  int fail_count;
  int pending;
  int checked;

  int pixels_sent = 0;
  int frames_sent = 0;
  bit calm_tx     = 1'b0;
  bit calm_rx     = 1'b0;
  int stall_left  = 0;
  int rx_cycles   = 0;
  int rx_roll;
  int idle_cycles = 0;

  sobel_edge_magnitude_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_i      (pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .edge_res_o   (edge_res),
    .center_row_o (center_row),
    .center_col_o (center_col),
    .frame_end_o  (frame_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  sobel_edge_magnitude_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .pixel_i      (pixel),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .edge_res_i   (edge_res),
    .center_row_i (center_row),
    .center_col_i (center_col),
    .frame_end_i  (frame_end),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result side back-pressure: mostly short stalls, a few long ones, and
  // calm stretches with no stall at all.
  always @(posedge clk_i) begin
    rx_cycles++;
    if (rx_cycles % 256 == 0) calm_rx = ($urandom_range(3) == 0);
    if (stall_left > 0) begin
      stall_left--;
    end else if (!calm_rx) begin
      rx_roll = $urandom_range(99);
      if (rx_roll >= 95) stall_left = $urandom_range(40, 10);
      else if (rx_roll >= 75) stall_left = $urandom_range(3, 1);
    end
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sobel_edge_magnitude_top_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_access(input logic is_write, input logic [sem_pkg::APB_ADDR_W-1:0] addr,
                            input logic [sem_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(input int unsigned cols_val, input int unsigned rows_val);
    cfg_access(1'b1, ADDR_COLS, cols_val);
    cfg_access(1'b1, ADDR_ROWS, rows_val);
    cfg_access(1'b0, ADDR_COLS, '0);
    cfg_access(1'b0, ADDR_ROWS, '0);
  endtask

  // This task lowers valid only for a gap; otherwise it stays high for the next item.
  task automatic push_pixel(input logic [sem_pkg::PIX_W-1:0] value);
    int gap;
    int roll;
    gap = 0;
    if (!calm_tx) begin
      roll = $urandom_range(99);
      if (roll >= 95) gap = $urandom_range(40, 10);
      else if (roll >= 70) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    do @(posedge clk_i); while (in_stall);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_pixels(input int count, input pattern_e pat);
    int                        k;
    int                        slope;
    logic [sem_pkg::PIX_W-1:0] base;
    logic [sem_pkg::PIX_W-1:0] v;
    base  = 8'($urandom_range(255));
    slope = $urandom_range(12) - 6;
    for (k = 0; k < count; k++) begin
      case (pat)
        PAT_NOISE:  v = 8'($urandom_range(255));
        PAT_BINARY: v = $urandom_range(1) ? 8'hFF : 8'h00;
        PAT_RAMP:   v = 8'(base + k * slope + $urandom_range(3));
        default:    v = ($urandom_range(7) == 0) ? ~base : base;
      endcase
      // Now and then hold the sender until every pending result is out.
      if (k > 0 && $urandom_range(199) == 0) wait_drained();
      push_pixel(v);
    end
  endtask

  initial begin
    int          k;
    int          start_count;
    int unsigned cols_eff;
    int unsigned rows_eff;
    int unsigned r0;
    int unsigned c0;
    int unsigned pos;
    int unsigned rows_new;
    int unsigned rows_new_eff;

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    cfg_access(1'b0, ADDR_COLS, '0);
    cfg_access(1'b0, ADDR_ROWS, '0);

    // Smallest frame: a hard vertical step that saturates, then a falling
    // diagonal ramp whose gradients are both negative.
    set_size(3, 3);
    calm_tx = 1'b1;
    for (k = 0; k < 9; k++) push_pixel((k % 3 == 2) ? 8'd255 : (k % 3 == 0) ? 8'd0 : 8'(k * 37));
    for (k = 0; k < 9; k++) push_pixel(8'(200 - 10 * (k / 3 + k % 3)));
    frames_sent += 2;
    wait_drained();

    // Both exact extremes and out-of-range sizes are written and read back.
    set_size(sem_pkg::MAX_COLS, sem_pkg::MAX_ROWS);
    set_size(12'hFFF, 13'h1FFF);

    // A clamped width lets the column count run far into the first row; a
    // narrower width then wraps it at the next pixel, and two short rows
    // close the frame.
    set_size(12'hFFF, 3);
    calm_tx = 1'b0;
    send_pixels(40, pattern_e'($urandom_range(3)));
    wait_drained();
    cfg_access(1'b1, ADDR_COLS, 5);
    send_pixels(11, pattern_e'($urandom_range(3)));
    frames_sent++;
    wait_drained();

    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      cols_eff = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
      rows_eff = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
      set_size(cols_eff, rows_eff);
      if (cols_eff < sem_pkg::MIN_SIZE) cols_eff = sem_pkg::MIN_SIZE;
      if (rows_eff < sem_pkg::MIN_SIZE) rows_eff = sem_pkg::MIN_SIZE;
      calm_tx = ($urandom_range(3) == 0);
      case ($urandom_range(4))
        0: begin
          if (cols_eff >= 4) begin
            // Stop inside a row, shrink the width below the current column
            // and the height to at most the next row: the next pixel closes
            // the frame.
            r0 = $urandom_range(rows_eff - 1, 2);
            c0 = $urandom_range(cols_eff - 1, 3);
            send_pixels(r0 * cols_eff + c0, pattern_e'($urandom_range(3)));
            wait_drained();
            cfg_access(1'b1, ADDR_COLS, $urandom_range(c0));
            cfg_access(1'b1, ADDR_ROWS, $urandom_range(r0 + 1));
            send_pixels(1, PAT_NOISE);
          end else begin
            send_pixels(cols_eff * rows_eff, pattern_e'($urandom_range(3)));
          end
        end
        1: begin
          // Change the height somewhere in the frame, keeping the width.
          r0  = $urandom_range(rows_eff - 1);
          c0  = $urandom_range(cols_eff - 1);
          pos = r0 * cols_eff + c0;
          send_pixels(pos, pattern_e'($urandom_range(3)));
          wait_drained();
          rows_new = $urandom_range(15);
          cfg_access(1'b1, ADDR_ROWS, rows_new);
          rows_new_eff = (rows_new < sem_pkg::MIN_SIZE) ? sem_pkg::MIN_SIZE : rows_new;
          if (r0 >= rows_new_eff) send_pixels(cols_eff - c0, pattern_e'($urandom_range(3)));
          else send_pixels(rows_new_eff * cols_eff - pos, pattern_e'($urandom_range(3)));
        end
        default: send_pixels(cols_eff * rows_eff, pattern_e'($urandom_range(3)));
      endcase
      frames_sent++;
      wait_drained();
    end

    $display("Run covered %0d pixels over %0d frames and checked %0d edge results,",
             pixels_sent, frames_sent, checked);
    $display("with small frames, clamped and extreme size registers, a long first row and mid-frame resizes.");
    if (fail_count == 0) begin
      $display("sobel_edge_magnitude_top_tb: PASS");
    end else begin
      $display("sobel_edge_magnitude_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/sem_pkg.sv
rtl/core/sem_ram.sv
rtl/core/sobel_edge_magnitude_top.sv
verif/sobel_edge_magnitude_checker.sv
verif/sobel_edge_magnitude_top_tb.sv
